>>> rtl/npms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npms_pkg
// Shared types and constants for the nearest point search unit.
// ----------------------------------------------------------------------------
package npms_pkg;

    localparam int MAX_POINTS = 16384;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int SCAN_W     = $clog2(MAX_POINTS + 1);

    localparam int CFG_W   = 15;
    localparam int SLOT_W  = 14;
    localparam int ID_W    = 31;
    localparam int LAT_W   = 25;
    localparam int LON_W   = 26;
    // |dlat| needs LAT_W bits, |dlon| LON_W bits, their sum one more
    localparam int DIST_W  = LON_W + 1;

    // beat kinds on the input tuser
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic signed [LAT_W-1:0] lat;
        logic signed [LON_W-1:0] lon;
    } t_point;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // sequencer -> datapath
    typedef struct packed {
        logic              start;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_scan_ctl;

    // datapath -> sequencer / output stage
    typedef struct packed {
        logic            busy;
        logic            have;
        logic [ID_W-1:0] best_id;
    } t_scan_stat;

endpackage
`default_nettype wire

>>> rtl/nearest_point_manhattan_search_unit.sv
// Load beat: written into the table on the accepting edge; ready again next cycle.
// Query beat: scans min(points_in_use, 16384) slots, one table read per cycle;
//   the result is registered after the datapath drains and the result register
//   is free, and the next beat can be taken in the cycle after that edge.
// Reset (i_rst_n low, synchronous): sequencer idle, no result pending,
//   points_in_use = 0. Table contents are not cleared.
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_point_manhattan_search_unit
// Point table with linear nearest-neighbor search by Manhattan distance.
// ----------------------------------------------------------------------------
module nearest_point_manhattan_search_unit
    import npms_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,

    // configuration: points_in_use
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CFG_W-1:0] i_cfg_data,

    // input beats
    input  wire logic             i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  wire logic [95:0]      i_s_axis_tdata,  // slot[13:0], point_id[44:14],
                                                   // latitude[69:45], longitude[95:70]
    input  wire logic             i_s_axis_tuser,  // action[0]

    // result beats
    output logic                  o_m_axis_tvalid,
    input  wire logic             i_m_axis_tready,
    output logic [31:0]           o_m_axis_tdata,  // nearest_id[30:0], zero pad[31]
    output logic                  o_m_axis_tuser   // found[0]
);

    // input field offsets in tdata
    localparam int SLOT_LSB = 0;
    localparam int ID_LSB   = SLOT_LSB + SLOT_W;
    localparam int LAT_LSB  = ID_LSB + ID_W;
    localparam int LON_LSB  = LAT_LSB + LAT_W;

    logic [CFG_W-1:0]        r_points_in_use;
    logic [SLOT_W-1:0]       w_slot;
    t_point                  w_wr_point;
    logic                    w_in_acc;
    logic                    w_wr_en;
    logic [SCAN_W-1:0]       w_scan_len;
    logic                    w_out_free;
    logic                    w_out_load;
    t_scan_ctl               w_ctl;
    t_scan_stat              w_stat;
    t_point                  w_rd_data;

    logic                    r_out_valid;
    logic                    r_out_found;
    logic [ID_W-1:0]         r_out_id;

    // ---- field unpack ----
    assign w_slot         = i_s_axis_tdata[SLOT_LSB +: SLOT_W];
    assign w_wr_point.id  = i_s_axis_tdata[ID_LSB +: ID_W];
    assign w_wr_point.lat = i_s_axis_tdata[LAT_LSB +: LAT_W];
    assign w_wr_point.lon = i_s_axis_tdata[LON_LSB +: LON_W];

    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;

    // loads past the table end are dropped
    assign w_wr_en = w_in_acc && (i_s_axis_tuser == ACT_LOAD)
                  && (32'(w_slot) < MAX_POINTS);

    // ---- config register, always writable ----
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points_in_use <= '0;
        end else if (i_cfg_valid) begin
            r_points_in_use <= i_cfg_data;
        end
    end

    // count beyond the table saturates at the table size
    assign w_scan_len = (32'(r_points_in_use) > MAX_POINTS) ? SCAN_W'(MAX_POINTS)
                                                            : SCAN_W'(r_points_in_use);

    // ---- point table ----
    npms_point_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_slot[ADDR_W-1:0]),
        .i_wr_data (w_wr_point),
        .i_rd_en   (w_ctl.rd_en),
        .i_rd_addr (w_ctl.rd_addr),
        .o_rd_data (w_rd_data)
    );

    // ---- scan sequencer ----
    npms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_query (i_s_axis_tuser == ACT_QUERY),
        .i_scan_len (w_scan_len),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_in_ready (o_s_axis_tready),
        .o_ctl      (w_ctl),
        .o_out_load (w_out_load)
    );

    // ---- distance datapath ----
    npms_dist u_dist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_q_lat   (w_wr_point.lat),
        .i_q_lon   (w_wr_point.lon),
        .i_rd_data (w_rd_data),
        .o_stat    (w_stat)
    );

    // ---- result register ----
    // A pending result does not block loads; a finished query waits here
    // in the sequencer until the register frees up.
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_found <= w_stat.have;
            r_out_id    <= w_stat.have ? w_stat.best_id : '0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_id};
    assign o_m_axis_tuser  = r_out_found;

endmodule
`default_nettype wire

>>> rtl/npms_point_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npms_point_ram
// Point table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module npms_point_ram
    import npms_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire t_point            i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output t_point                 o_rd_data
);

    t_point r_mem [MAX_POINTS];
    t_point r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

>>> rtl/npms_dist.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npms_dist
// Distance datapath: absolute differences, then sum and best-so-far update.
// ----------------------------------------------------------------------------
module npms_dist
    import npms_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_scan_ctl               i_ctl,
    input  wire logic signed [LAT_W-1:0] i_q_lat,
    input  wire logic signed [LON_W-1:0] i_q_lon,
    input  wire t_point                  i_rd_data,
    output t_scan_stat                   o_stat
);

    logic signed [LAT_W-1:0] r_q_lat;
    logic signed [LON_W-1:0] r_q_lon;
    logic                    r_s1_valid;
    logic                    r_s2_valid;
    logic [LAT_W-1:0]        r_alat;
    logic [LON_W-1:0]        r_alon;
    logic [ID_W-1:0]         r_s2_id;
    logic                    r_have;
    logic [DIST_W-1:0]       r_best_dist;
    logic [ID_W-1:0]         r_best_id;

    logic signed [LAT_W:0]   w_dlat;
    logic signed [LON_W:0]   w_dlon;
    logic [LAT_W-1:0]        w_alat;
    logic [LON_W-1:0]        w_alon;
    logic [DIST_W-1:0]       w_dist;
    logic                    w_take;

    // stage 1: magnitudes of the coordinate differences
    always_comb begin
        w_dlat = $signed({r_q_lat[LAT_W-1], r_q_lat})
               - $signed({i_rd_data.lat[LAT_W-1], i_rd_data.lat});
        w_dlon = $signed({r_q_lon[LON_W-1], r_q_lon})
               - $signed({i_rd_data.lon[LON_W-1], i_rd_data.lon});
        w_alat = w_dlat[LAT_W] ? LAT_W'(-w_dlat) : w_dlat[LAT_W-1:0];
        w_alon = w_dlon[LON_W] ? LON_W'(-w_dlon) : w_dlon[LON_W-1:0];
    end

    // stage 2: sum and strict compare, so ties keep the lower slot
    always_comb begin
        w_dist = DIST_W'(r_alat) + DIST_W'(r_alon);
        w_take = r_s2_valid && (!r_have || (w_dist < r_best_dist));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_have     <= 1'b0;
        end else begin
            r_s1_valid <= i_ctl.rd_en;
            r_s2_valid <= r_s1_valid;
            if (i_ctl.start) begin
                r_have <= 1'b0;
            end else if (w_take) begin
                r_have <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_q_lat <= i_q_lat;
            r_q_lon <= i_q_lon;
        end
        r_alat  <= w_alat;
        r_alon  <= w_alon;
        r_s2_id <= i_rd_data.id;
        if (w_take) begin
            r_best_dist <= w_dist;
            r_best_id   <= r_s2_id;
        end
    end

    assign o_stat.busy    = r_s1_valid | r_s2_valid;
    assign o_stat.have    = r_have;
    assign o_stat.best_id = r_best_id;

endmodule
`default_nettype wire

>>> rtl/npms_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npms_ctrl
// Scan sequencer: walks slots 0..n-1, drains the datapath, hands off result.
// ----------------------------------------------------------------------------
module npms_ctrl
    import npms_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_query,
    input  wire logic [SCAN_W-1:0] i_scan_len,
    input  wire logic              i_out_free,
    input  wire t_scan_stat        i_stat,
    output logic                   o_in_ready,
    output t_scan_ctl              o_ctl,
    output logic                   o_out_load
);

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [SCAN_W-1:0]   r_left, n_left;
    logic                w_start;

    assign w_start = (r_state == ST_IDLE) && i_in_valid && i_in_query;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_start) begin
                    n_state = (i_scan_len == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_left == SCAN_W'(1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_stat.busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // slot counter
    always_comb begin
        n_addr = r_addr;
        n_left = r_left;
        if (w_start) begin
            n_addr = '0;
            n_left = i_scan_len;
        end else if (r_state == ST_SCAN) begin
            n_addr = r_addr + ADDR_W'(1);
            n_left = r_left - SCAN_W'(1);
        end
    end

    // outputs
    always_comb begin
        o_in_ready    = (r_state == ST_IDLE);
        o_ctl.start   = w_start;
        o_ctl.rd_en   = (r_state == ST_SCAN);
        o_ctl.rd_addr = r_addr;
        o_out_load    = (r_state == ST_DONE) && i_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_addr  <= '0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_left  <= n_left;
        end
    end

endmodule
`default_nettype wire

>>> rtl/npms_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npms_checker
// Port-level checks for the nearest point search unit, bound to the top.
// ----------------------------------------------------------------------------
module npms_checker
    import npms_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic        i_s_axis_tuser,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [31:0] o_m_axis_tdata,
    input wire logic        o_m_axis_tuser
);

    // no result survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("result beat changed while stalled");

    // an empty scan reports a zero id
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata == 32'd0))
        else $error("nonzero id with found low");

    // a query occupies the unit: no beat taken the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == ACT_QUERY)) |=>
        !o_s_axis_tready)
        else $error("input ready right after query accept");

endmodule

bind nearest_point_manhattan_search_unit npms_checker u_npms_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
`default_nettype wire
